FILE: rtl/tsw_pkg.sv
// tsw_pkg: shared codes, command set and status bundle for the transport sender
// used by tsw_ctrl, tsw_dp and the top level
`default_nettype none

package tsw_pkg;

  localparam int FuncW  = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 80;
  localparam int OutDataW = 96;

  localparam logic [FuncW-1:0] FUNC_WRITE = 3'd0;
  localparam logic [FuncW-1:0] FUNC_ACK   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_TICK  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_FILL  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_EMPTY = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_ISN      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_WRITE,
    CMD_UNWRAP,
    CMD_ACK_SET,
    CMD_POP,
    CMD_ACK_FREE,
    CMD_SYN_MARK,
    CMD_SYN_SEG,
    CMD_FIN_PROBE,
    CMD_BYTE_PROBE,
    CMD_DATA_SEG,
    CMD_TIMER_STOP,
    CMD_TIMER_ADD,
    CMD_BACKOFF,
    CMD_RESEND_EMPTY
  } cmd_e;

  typedef struct packed {
    logic ack_bad;
    logic pop_ok;
    logic syn_done;
    logic head_syn;
    logic fill_idle;
    logic peer_zero;
    logic q_empty;
    logic q_full;
    logic probe_fin;
    logic sb_nz;
    logic sb_drain;
    logic loop_go;
    logic timer_on;
    logic expired;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/tsw_dp.sv
// tsw_dp: sender state, outstanding segment queue memory and output word register
// depends on tsw_pkg; driven by commands from tsw_ctrl
`default_nettype none

module tsw_dp #(
  parameter int MAX_PAYLOAD = 1000,
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tsw_pkg::cmd_e                 cmd_i,
  input  wire logic                          resend_i,
  output tsw_pkg::status_t                   status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tsw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [15:0]                   write_count_i,
  input  wire logic                          write_end_i,
  input  wire logic [31:0]                   ack_number_i,
  input  wire logic [15:0]                   window_i,
  input  wire logic [15:0]                   elapsed_ms_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [31:0]                        seg_seqno_o,
  output logic [9:0]                         payload_len_o,
  output logic                               syn_flag_o,
  output logic                               fin_flag_o,
  output logic                               resend_o,
  output logic                               last_o,
  output logic [15:0]                        retx_count_o,
  output logic [31:0]                        in_flight_o
);
  import tsw_pkg::*;

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int Cap = (MAX_PAYLOAD > 1023) ? 1023 : MAX_PAYLOAD;
  localparam logic [15:0] CAP16 = 16'(Cap);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_SLOT = HW'(QUEUE_DEPTH - 1);
  localparam logic [CW:0] DEPTH_W = (CW+1)'(QUEUE_DEPTH);
  localparam logic [31:0] HALF = 32'h8000_0000;

  logic [31:0] isn_q, init_to_q;
  logic [15:0] cap_q;
  logic [63:0] next_q, abs_q;
  logic [31:0] unacked_q;
  logic [HW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [15:0] sb_q, peer_q, free_q, retx_q;
  logic ended_q, syn_done_q, fin_done_q, timer_on_q;
  logic [31:0] timer_q, timeout_q;
  logic [15:0] wcount_q, win_q, elapsed_q;
  logic wend_q;
  logic [31:0] ack_q;

  logic [75:0] mem_q [QUEUE_DEPTH];
  logic [75:0] rd_q;

  logic [63:0] rd_start;
  logic [9:0] rd_len;
  logic rd_syn, rd_fin;
  logic [15:0] rd_sl;

  assign rd_start = rd_q[75:12];
  assign rd_len   = rd_q[9:0];
  assign rd_syn   = rd_q[10];
  assign rd_fin   = rd_q[11];
  assign rd_sl    = 16'(rd_len) + 16'(rd_syn) + 16'(rd_fin);

  // data segment sizing
  logic [15:0] n_min, n16;
  logic dfin;
  assign n_min = (sb_q < free_q) ? sb_q : free_q;
  assign n16   = (n_min > CAP16) ? CAP16 : n_min;
  assign dfin  = ended_q && (sb_q == n16) && (free_q > n16);

  logic [9:0] seg_len;
  logic seg_syn, seg_fin, do_send, do_emit;
  always_comb begin
    seg_len = '0;
    seg_syn = 1'b0;
    seg_fin = 1'b0;
    case (cmd_i)
      CMD_SYN_SEG:    seg_syn = 1'b1;
      CMD_FIN_PROBE:  seg_fin = 1'b1;
      CMD_BYTE_PROBE: seg_len = 10'd1;
      CMD_DATA_SEG: begin
        seg_len = n16[9:0];
        seg_fin = dfin;
      end
      default: ;
    endcase
  end

  assign do_send = (cmd_i == CMD_SYN_SEG) || (cmd_i == CMD_FIN_PROBE) ||
                   (cmd_i == CMD_BYTE_PROBE) || (cmd_i == CMD_DATA_SEG);
  assign do_emit = do_send || (cmd_i == CMD_RESEND_EMPTY);

  logic [15:0] sl16, free_nx;
  logic [CW-1:0] count_nx;
  logic [CW:0] slot_sum;
  logic [HW-1:0] slot;
  logic data_last;
  assign sl16      = 16'(seg_len) + 16'(seg_syn) + 16'(seg_fin);
  assign free_nx   = (free_q > sl16) ? free_q - sl16 : 16'd0;
  assign count_nx  = count_q + CW'(1);
  assign slot_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign slot      = (slot_sum >= DEPTH_W) ? HW'(slot_sum - DEPTH_W) : HW'(slot_sum);
  assign data_last = (sb_q == n16) || (free_nx == 16'd0) || (count_nx == DEPTH_C);

  // ack number unwrap
  logic [31:0] off, lo, hi;
  logic [63:0] abs_nx;
  assign off = ack_q - isn_q;
  assign lo  = next_q[31:0];
  assign hi  = next_q[63:32];
  always_comb begin
    if (off > lo && (off - lo) > HALF && hi != 32'd0) begin
      abs_nx = {hi - 32'd1, off};
    end else if (off < lo && (lo - off) > HALF) begin
      abs_nx = {hi + 32'd1, off};
    end else begin
      abs_nx = {hi, off};
    end
  end

  logic [63:0] gap;
  logic [15:0] ack_free;
  assign gap      = next_q - abs_q;
  assign ack_free = (gap < 64'(win_q)) ? win_q - gap[15:0] : 16'd0;

  logic [32:0] tsum;
  assign tsum = {1'b0, timer_q} + 33'(elapsed_q);

  logic [15:0] room, add_n;
  assign room  = (sb_q < cap_q) ? cap_q - sb_q : 16'd0;
  assign add_n = (wcount_q < room) ? wcount_q : room;

  always_comb begin
    status_o.ack_bad   = (abs_q > next_q) || (count_q != '0 && abs_q < rd_start);
    status_o.pop_ok    = (count_q != '0) && ((rd_start + 64'(rd_sl)) <= abs_q);
    status_o.syn_done  = syn_done_q;
    status_o.head_syn  = (count_q != '0) && rd_syn;
    status_o.fill_idle = (sb_q == 16'd0 && !ended_q) || fin_done_q;
    status_o.peer_zero = (peer_q == 16'd0);
    status_o.q_empty   = (count_q == '0);
    status_o.q_full    = (count_q == DEPTH_C);
    status_o.probe_fin = ended_q && (sb_q == 16'd0);
    status_o.sb_nz     = (sb_q != 16'd0);
    status_o.sb_drain  = (sb_q == n16);
    status_o.loop_go   = (free_q != 16'd0) && (count_q != DEPTH_C);
    status_o.timer_on  = timer_on_q;
    status_o.expired   = (timer_q >= timeout_q);
    status_o.out_free  = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (do_send) begin
      mem_q[slot] <= {next_q, seg_fin, seg_syn, seg_len};
    end
    rd_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      wcount_q  <= write_count_i;
      wend_q    <= write_end_i;
      ack_q     <= ack_number_i;
      win_q     <= window_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (cmd_i == CMD_UNWRAP) begin
      abs_q <= abs_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isn_q       <= '0;
      init_to_q   <= 32'd1000;
      cap_q       <= 16'hffff;
      next_q      <= '0;
      unacked_q   <= '0;
      head_q      <= '0;
      count_q     <= '0;
      sb_q        <= '0;
      ended_q     <= 1'b0;
      peer_q      <= '0;
      free_q      <= '0;
      syn_done_q  <= 1'b0;
      fin_done_q  <= 1'b0;
      timer_on_q  <= 1'b0;
      timer_q     <= '0;
      timeout_q   <= 32'd1000;
      retx_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ISN: isn_q <= cfg_data_i;
          CFG_TIMEOUT: begin
            init_to_q <= {16'd0, cfg_data_i[15:0]};
            timeout_q <= {16'd0, cfg_data_i[15:0]};
          end
          CFG_CAPACITY: cap_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (do_send) begin
        next_q    <= next_q + 64'(sl16);
        unacked_q <= unacked_q + 32'(sl16);
        free_q    <= free_nx;
        count_q   <= count_nx;
        if (!timer_on_q) begin
          timer_on_q <= 1'b1;
          timer_q    <= '0;
        end
      end
      case (cmd_i)
        CMD_WRITE: begin
          if (!ended_q) sb_q <= sb_q + add_n;
          if (wend_q) ended_q <= 1'b1;
        end
        CMD_ACK_SET: begin
          peer_q <= win_q;
          free_q <= win_q;
        end
        CMD_POP: begin
          unacked_q <= unacked_q - 32'(rd_sl);
          head_q    <= (head_q == LAST_SLOT) ? '0 : head_q + HW'(1);
          count_q   <= count_q - CW'(1);
          timer_q   <= '0;
          timeout_q <= init_to_q;
          retx_q    <= '0;
        end
        CMD_ACK_FREE: begin
          if (count_q != '0) free_q <= ack_free;
          if (unacked_q == 32'd0) timer_on_q <= 1'b0;
        end
        CMD_SYN_MARK, CMD_SYN_SEG: syn_done_q <= 1'b1;
        CMD_FIN_PROBE: fin_done_q <= 1'b1;
        CMD_BYTE_PROBE: sb_q <= sb_q - 16'd1;
        CMD_DATA_SEG: begin
          sb_q <= sb_q - n16;
          if (dfin) fin_done_q <= 1'b1;
        end
        CMD_TIMER_STOP: timer_on_q <= 1'b0;
        CMD_TIMER_ADD: timer_q <= tsum[32] ? 32'hffff_ffff : tsum[31:0];
        CMD_BACKOFF: begin
          if (peer_q != 16'd0 || rd_syn) begin
            if (retx_q != 16'hffff) retx_q <= retx_q + 16'd1;
            timeout_q <= timeout_q[31] ? 32'hffff_ffff : {timeout_q[30:0], 1'b0};
          end
          timer_q <= '0;
        end
        default: ;
      endcase
      if (do_emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (do_send) begin
      seg_seqno_o   <= next_q[31:0] + isn_q;
      payload_len_o <= seg_len;
      syn_flag_o    <= seg_syn;
      fin_flag_o    <= seg_fin;
      resend_o      <= 1'b0;
      last_o        <= (cmd_i == CMD_DATA_SEG) ? data_last : 1'b1;
      retx_count_o  <= retx_q;
      in_flight_o   <= unacked_q + 32'(sl16);
    end else if (cmd_i == CMD_RESEND_EMPTY) begin
      seg_seqno_o   <= (resend_i ? rd_start[31:0] : next_q[31:0]) + isn_q;
      payload_len_o <= resend_i ? rd_len : 10'd0;
      syn_flag_o    <= resend_i && rd_syn;
      fin_flag_o    <= resend_i && rd_fin;
      resend_o      <= resend_i;
      last_o        <= 1'b1;
      retx_count_o  <= retx_q;
      in_flight_o   <= unacked_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tsw_ctrl.sv
// tsw_ctrl: sequencer that steps each input word through its command sequence
// depends on tsw_pkg; drives tsw_dp
`default_nettype none

module tsw_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tsw_pkg::FuncW-1:0]  func_i,
  input  wire tsw_pkg::status_t           status_i,
  output tsw_pkg::cmd_e                   cmd_o,
  output logic                            resend_o
);
  import tsw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_ACK_UNWRAP, S_ACK_CHK, S_ACK_POP, S_ACK_RD,
    S_FILL_RD, S_FILL_DEC, S_FILL_LOOP, S_TICK, S_TICK_CHK, S_TICK_EMIT, S_EMPTY
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    cmd_o    = CMD_NONE;
    resend_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
          case (func_i)
            FUNC_WRITE: state_d = S_WRITE;
            FUNC_ACK:   state_d = S_ACK_UNWRAP;
            FUNC_TICK:  state_d = S_TICK;
            FUNC_FILL:  state_d = S_FILL_RD;
            FUNC_EMPTY: state_d = S_EMPTY;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o   = CMD_WRITE;
        state_d = S_IDLE;
      end
      S_ACK_UNWRAP: begin
        cmd_o   = CMD_UNWRAP;
        state_d = S_ACK_CHK;
      end
      S_ACK_CHK: begin
        if (status_i.ack_bad) begin
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_ACK_SET;
          state_d = S_ACK_POP;
        end
      end
      S_ACK_POP: begin
        if (status_i.pop_ok) begin
          cmd_o   = CMD_POP;
          state_d = S_ACK_RD;
        end else begin
          cmd_o   = CMD_ACK_FREE;
          state_d = S_FILL_RD;
        end
      end
      S_ACK_RD: state_d = S_ACK_POP;
      S_FILL_RD: state_d = S_FILL_DEC;
      S_FILL_DEC: begin
        if (!status_i.syn_done) begin
          if (status_i.q_full) begin
            cmd_o   = CMD_SYN_MARK;
            state_d = S_IDLE;
          end else if (status_i.out_free) begin
            cmd_o   = CMD_SYN_SEG;
            state_d = S_IDLE;
          end
        end else if (status_i.head_syn || status_i.fill_idle) begin
          state_d = S_IDLE;
        end else if (!status_i.peer_zero) begin
          state_d = S_FILL_LOOP;
        end else if (!status_i.q_empty) begin
          state_d = S_IDLE;
        end else if (status_i.probe_fin) begin
          if (status_i.out_free) begin
            cmd_o   = CMD_FIN_PROBE;
            state_d = S_IDLE;
          end
        end else if (status_i.sb_nz) begin
          if (status_i.out_free) begin
            cmd_o   = CMD_BYTE_PROBE;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FILL_LOOP: begin
        if (!status_i.loop_go) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o = CMD_DATA_SEG;
          if (status_i.sb_drain) state_d = S_IDLE;
        end
      end
      S_TICK: begin
        if (!status_i.timer_on) begin
          state_d = S_IDLE;
        end else if (status_i.q_empty) begin
          cmd_o   = CMD_TIMER_STOP;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_TIMER_ADD;
          state_d = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (status_i.expired) begin
          cmd_o   = CMD_BACKOFF;
          state_d = S_TICK_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TICK_EMIT: begin
        resend_o = 1'b1;
        if (status_i.out_free) begin
          cmd_o   = CMD_RESEND_EMPTY;
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_RESEND_EMPTY;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcp_sender_window_retransmit.sv
// tcp_sender_window_retransmit: top level of the transport sender
// depends on tsw_pkg, tsw_ctrl and tsw_dp
//
// Input words (s_axis) carry a request kind in tuser: write bytes, ack,
// timer tick, fill window or empty segment. Output words (m_axis) carry
// segment descriptors, tlast on the last one caused by an input word.
// Configuration (initial sequence number, initial timeout, stream
// capacity) is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle, as the block does not enforce it.
// One word is worked on at a time; tready is high only when idle.
// A good ack pops every fully acknowledged segment and then runs a fill;
// a bad ack is dropped. The queue memory's read port is registered, so a
// read state follows every pop and comes before each head lookup.
// The result word sits in an output register, so the next segment is
// formed in the same cycle the previous one is taken; a stalled receiver
// holds the sequencer until the register frees.
// Reset clears all control state; the queue memory needs no clearing.
`default_nettype none

module tcp_sender_window_retransmit #(
  parameter int MAX_PAYLOAD = 1000,
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // write_count, ack_number, window, elapsed_ms
  input  wire logic [tsw_pkg::InDataW-1:0]   s_axis_tdata,
  // write_end
  input  wire logic                          s_axis_tlast,
  // func
  input  wire logic [tsw_pkg::FuncW-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // seg_seqno, payload_len, syn_flag, fin_flag, resend, retx_count, in_flight, zero pad
  output logic [tsw_pkg::OutDataW-1:0]       m_axis_tdata,
  // last
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tsw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tsw_pkg::*;

  localparam int Cap = (MAX_PAYLOAD > 1023) ? 1023 : MAX_PAYLOAD;
  localparam logic [9:0] CAP10 = 10'(Cap);

  cmd_e cmd;
  status_t status;
  logic resend_sel;
  logic [31:0] seg_seqno, in_flight;
  logic [9:0] payload_len;
  logic syn_flag, fin_flag, resend;
  logic [15:0] retx_count;

  tsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd),
    .resend_o   (resend_sel)
  );

  tsw_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .resend_i      (resend_sel),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .write_count_i (s_axis_tdata[15:0]),
    .write_end_i   (s_axis_tlast),
    .ack_number_i  (s_axis_tdata[47:16]),
    .window_i      (s_axis_tdata[63:48]),
    .elapsed_ms_i  (s_axis_tdata[79:64]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .seg_seqno_o   (seg_seqno),
    .payload_len_o (payload_len),
    .syn_flag_o    (syn_flag),
    .fin_flag_o    (fin_flag),
    .resend_o      (resend),
    .last_o        (m_axis_tlast),
    .retx_count_o  (retx_count),
    .in_flight_o   (in_flight)
  );

  assign m_axis_tdata = {3'b000, in_flight, retx_count, resend, fin_flag, syn_flag,
                         payload_len, seg_seqno};

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> payload_len <= CAP10)
    else $error("payload above segment cap");

  a_syn_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(syn_flag && fin_flag))
    else $error("segment with both syn and fin");

  a_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !resend && (payload_len != 10'd0 || syn_flag || fin_flag))
      |-> in_flight != 32'd0)
    else $error("new segment sent but nothing in flight");

endmodule

`default_nettype wire
